@@ hw/rtl/qrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants for the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int QW        = 16;   // input component width, Q2.14
    localparam int OW        = 18;   // output entry width, Q1.16
    localparam int NW        = 33;   // squared norm width
    localparam int DVW       = 34;   // divisor 2n width
    localparam int REMW      = 50;   // dividend / remainder width
    localparam int QUOW      = 17;   // quotient width
    localparam int NLANE     = 9;
    localparam logic [QUOW-1:0] Q16_ONE = 17'd65536;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [QUOW-1:0] quo;
        logic            neg;
    } t_lane;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [DVW-1:0]       dvs;
        t_lane [NLANE-1:0]    lane;
    } t_div;

endpackage

@@ hw/rtl/quaternion_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q2.14 quaternion of any length into a Q1.16 3x3 rotation matrix.
//
// Channel  Direction  Handshake             Payload
// input    in         i_valid / o_stall     i_quat_w, i_quat_x, i_quat_y, i_quat_z
// output   out        o_valid / i_stall     o_m00 .. o_m22, o_zero_norm
//
// Four front stages, seventeen divider stages (one quotient bit each) and one
// output stage. One transaction enters per cycle unless o_stall is high.
// Reset clears only the valid bits. While a result waits under i_stall the
// whole pipeline holds, and o_stall is raised to the input side.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [QW-1:0] i_quat_w,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [OW-1:0] o_m00,
    output logic signed [OW-1:0] o_m01,
    output logic signed [OW-1:0] o_m02,
    output logic signed [OW-1:0] o_m10,
    output logic signed [OW-1:0] o_m11,
    output logic signed [OW-1:0] o_m12,
    output logic signed [OW-1:0] o_m20,
    output logic signed [OW-1:0] o_m21,
    output logic signed [OW-1:0] o_m22,
    output logic                 o_zero_norm
);

    logic              en;
    t_div              stg [QUOW+1];
    logic              r_valid;
    logic              r_zero;
    logic [OW-1:0]     r_m [NLANE];
    logic [OW-1:0]     n_m [NLANE];
    logic [QUOW-1:0]   q;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    qrm_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_div   (stg[0])
    );

    for (genvar g = 0; g < QUOW; g++) begin : g_div
        qrm_div_stage #(.BIT(QUOW - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (stg[g]),
            .o_div   (stg[g+1])
        );
    end

    // Clamp, restore the sign, and substitute the identity for a zero norm.
    always_comb begin
        q = '0;
        for (int k = 0; k < NLANE; k++) begin
            q = (stg[QUOW].lane[k].quo > Q16_ONE) ? Q16_ONE : stg[QUOW].lane[k].quo;
            if (stg[QUOW].zero) begin
                n_m[k] = (k % 4 == 0) ? OW'(Q16_ONE) : '0;
            end else if (stg[QUOW].lane[k].neg) begin
                n_m[k] = OW'(-{1'b0, q});
            end else begin
                n_m[k] = OW'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= stg[QUOW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= stg[QUOW].zero;
            for (int k = 0; k < NLANE; k++) begin
                r_m[k] <= n_m[k];
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_zero_norm = r_zero;
    assign o_m00       = r_m[0];
    assign o_m01       = r_m[1];
    assign o_m02       = r_m[2];
    assign o_m10       = r_m[3];
    assign o_m11       = r_m[4];
    assign o_m12       = r_m[5];
    assign o_m20       = r_m[6];
    assign o_m21       = r_m[7];
    assign o_m22       = r_m[8];

endmodule

@@ hw/rtl/qrm_products.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_products
// Front pipeline: input register, ten products, norm and numerators, and the
// dividends and divisor handed to the divider stages.
// ----------------------------------------------------------------------------
module qrm_products
    import qrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [QW-1:0] i_w,
    input  logic signed [QW-1:0] i_x,
    input  logic signed [QW-1:0] i_y,
    input  logic signed [QW-1:0] i_z,
    output t_div                 o_div
);

    // Stage 1: input register.
    logic                 r_v1;
    logic signed [QW-1:0] r_w, r_x, r_y, r_z;

    // Stage 2: products.
    logic                   r_v2;
    logic signed [2*QW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    // Stage 3: norm and numerators.
    logic               r_v3;
    logic [NW-1:0]      r_n;
    logic signed [35:0] r_num [NLANE];

    // Stage 4: dividends.
    t_div r_div;

    logic [NW-1:0]      n_n;
    logic signed [35:0] n_num [NLANE];
    logic signed [35:0] s_n;
    t_div               n_div;
    logic [35:0]        mag;

    always_comb begin
        n_n = NW'(r_ww) + NW'(r_xx) + NW'(r_yy) + NW'(r_zz);
        s_n = 36'($signed({3'b000, n_n}));
        n_num[0] = s_n - 36'(r_yy) * 2 - 36'(r_zz) * 2;
        n_num[1] = (36'(r_xy) - 36'(r_wz)) * 2;
        n_num[2] = (36'(r_xz) + 36'(r_wy)) * 2;
        n_num[3] = (36'(r_xy) + 36'(r_wz)) * 2;
        n_num[4] = s_n - 36'(r_xx) * 2 - 36'(r_zz) * 2;
        n_num[5] = (36'(r_yz) - 36'(r_wx)) * 2;
        n_num[6] = (36'(r_xz) - 36'(r_wy)) * 2;
        n_num[7] = (36'(r_yz) + 36'(r_wx)) * 2;
        n_num[8] = s_n - 36'(r_xx) * 2 - 36'(r_yy) * 2;
    end

    always_comb begin
        n_div       = '0;
        n_div.valid = r_v3;
        n_div.zero  = (r_n == '0);
        n_div.dvs   = {r_n, 1'b0};
        mag         = '0;
        for (int k = 0; k < NLANE; k++) begin
            mag = r_num[k][35] ? 36'(-r_num[k]) : 36'(r_num[k]);
            n_div.lane[k].neg = r_num[k][35];
            n_div.lane[k].quo = '0;
            n_div.lane[k].rem = {mag[32:0], 17'd0} + REMW'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_div.valid <= n_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w  <= i_w;
            r_x  <= i_x;
            r_y  <= i_y;
            r_z  <= i_z;
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xy <= r_x * r_y;
            r_xz <= r_x * r_z;
            r_yz <= r_y * r_z;
            r_wx <= r_w * r_x;
            r_wy <= r_w * r_y;
            r_wz <= r_w * r_z;
            r_n  <= n_n;
            for (int k = 0; k < NLANE; k++) begin
                r_num[k] <= n_num[k];
            end
            r_div.zero <= n_div.zero;
            r_div.dvs  <= n_div.dvs;
            r_div.lane <= n_div.lane;
        end
    end

    assign o_div = r_div;

endmodule

@@ hw/rtl/qrm_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine lanes: settles one quotient bit.
// ----------------------------------------------------------------------------
module qrm_div_stage
    import qrm_pkg::*;
#(
    parameter int BIT = 16
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    t_div            r_div;
    t_div            n_div;
    logic [REMW-1:0] sh;

    always_comb begin
        n_div = i_div;
        sh    = REMW'(i_div.dvs) << BIT;
        for (int k = 0; k < NLANE; k++) begin
            if (i_div.lane[k].rem >= sh) begin
                n_div.lane[k].rem      = i_div.lane[k].rem - sh;
                n_div.lane[k].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_div.valid <= n_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.zero <= n_div.zero;
            r_div.dvs  <= n_div.dvs;
            r_div.lane <= n_div.lane;
        end
    end

    assign o_div = r_div;

endmodule
